[sv/tml_pkg.sv]
// Package for the triplet margin loss block: types, codes and fixed widths.
`default_nettype none
package tml_pkg;

    localparam int MaxDim    = 256;
    localparam int FracBits  = 16;
    localparam int ElemW     = 24;
    localparam int OutW      = 34;
    localparam int DiffW     = 58;
    localparam int DotW      = 57;
    localparam int NormW     = 56;
    localparam int CntW      = $clog2(MaxDim + 1);
    localparam int InDataW   = 3 * ElemW;
    localparam int OutDataW  = ((3 * OutW + 7) / 8) * 8;

    localparam logic [1:0] MetricEuclid = 2'd0;
    localparam logic [1:0] MetricCosine = 2'd1;
    localparam logic [1:0] MetricManhat = 2'd2;

    localparam logic [1:0] RegMetric = 2'd0;
    localparam logic [1:0] RegMargin = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_FSEL, ST_SQA, ST_SQB, ST_SQD,
        ST_MULD, ST_DIVC, ST_DIV, ST_STORE, ST_LOSS
    } t_state;

endpackage
`default_nettype wire

[sv/triplet_margin_loss.sv]
// Triplet margin loss over streamed embedding components, one shared multiplier and sqrt unit.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: anchor, positive, negative; tlast: last component
//  m_axis    out        tdata: loss, anchor-positive dist, anchor-negative dist
//  cfg       in         write enable, index, data (metric, margin)
//
// Each component passes MUL and ACC twice (Manhattan, Euclidean) or five times (cosine),
// one product of the single multiplier or a Manhattan absolute difference per pass. The last
// component adds a finish per pair: a 32-step square root for Euclidean; for cosine, unless
// a norm is zero, two square roots, a product and a 16-step divide. The block is not ready
// while it works. A finished result waits in the output register; a new input beat is taken
// meanwhile. Synchronous reset clears the accumulators, counters and output valid.
`default_nettype none
module triplet_margin_loss (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // anchor_elem [23:0], positive_elem [47:24], negative_elem [71:48]
    input  wire  [tml_pkg::InDataW-1:0]  s_axis_tdata,
    input  wire                          s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // loss_value [33:0], dist_positive [67:34], dist_negative [101:68], zero fill above
    output logic [tml_pkg::OutDataW-1:0] m_axis_tdata,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_idx,
    input  wire  [23:0]                  i_cfg_data
);
    import tml_pkg::*;

    localparam logic [OutW-1:0]  OutMax  = '1;
    localparam logic [DiffW-1:0] DiffMax = '1;
    localparam logic [NormW-1:0] NormMax = '1;
    localparam logic [17:0]      OneFix  = 18'(1) << FracBits;

    t_state r_state, n_state;

    logic [1:0]        r_mode;
    logic [23:0]       r_margin;
    logic signed [ElemW-1:0] r_a, r_p, r_n;
    logic              r_last;
    logic [CntW-1:0]   r_cnt_elem;
    logic [2:0]        r_k;
    logic [63:0]       r_prod;

    logic [DiffW-1:0]  r_acc_p, r_acc_n;
    logic signed [DotW-1:0] r_dot_p, r_dot_n;
    logic [NormW-1:0]  r_norm_a, r_norm_p, r_norm_n;

    logic              r_pair;
    logic [63:0]       r_sq_v, r_sq_r;
    logic [4:0]        r_step;
    logic [31:0]       r_sa, r_sb;
    logic [63:0]       r_den, r_rem;
    logic [16:0]       r_q;
    logic [OutW-1:0]   r_d, r_dap, r_dan;
    logic              r_out_valid;
    logic [3*OutW-1:0] r_out;

    // Operand selection for the shared multiplier.
    logic signed [ElemW:0]   w_dp, w_dn;
    logic signed [32:0]      w_mx, w_my;
    logic signed [65:0]      w_mul;
    logic [ElemW:0]          w_abs_p, w_abs_n;
    logic [2:0]              w_k_last;

    assign w_dp = (ElemW+1)'(r_a) - (ElemW+1)'(r_p);
    assign w_dn = (ElemW+1)'(r_a) - (ElemW+1)'(r_n);
    assign w_abs_p = w_dp[ElemW] ? (ElemW+1)'(-w_dp) : w_dp;
    assign w_abs_n = w_dn[ElemW] ? (ElemW+1)'(-w_dn) : w_dn;
    assign w_k_last = (r_mode == MetricCosine) ? 3'd4 : 3'd1;

    always_comb begin
        w_mx = '0;
        w_my = '0;
        if (r_state == ST_MULD) begin
            w_mx = {1'b0, r_sa};
            w_my = {1'b0, r_sb};
        end else if (r_mode == MetricCosine) begin
            case (r_k)
                3'd0:    begin w_mx = 33'(r_a); w_my = 33'(r_p); end
                3'd1:    begin w_mx = 33'(r_a); w_my = 33'(r_n); end
                3'd2:    begin w_mx = 33'(r_a); w_my = 33'(r_a); end
                3'd3:    begin w_mx = 33'(r_p); w_my = 33'(r_p); end
                default: begin w_mx = 33'(r_n); w_my = 33'(r_n); end
            endcase
        end else if (r_k == 3'd0) begin
            w_mx = 33'(w_dp);
            w_my = 33'(w_dp);
        end else begin
            w_mx = 33'(w_dn);
            w_my = 33'(w_dn);
        end
    end
    assign w_mul = w_mx * w_my;

    // Saturating accumulation of the registered product.
    logic [DiffW:0]  w_sum_diff;
    logic [NormW:0]  w_sum_norm;
    logic signed [DotW:0] w_sum_dot;
    logic [DiffW-1:0] w_acc_sel;
    logic [NormW-1:0] w_norm_sel;
    logic signed [DotW-1:0] w_dot_sel;

    always_comb begin
        w_acc_sel  = (r_k == 3'd0) ? r_acc_p : r_acc_n;
        w_dot_sel  = (r_k == 3'd0) ? r_dot_p : r_dot_n;
        case (r_k)
            3'd2:    w_norm_sel = r_norm_a;
            3'd3:    w_norm_sel = r_norm_p;
            default: w_norm_sel = r_norm_n;
        endcase
    end
    assign w_sum_diff = {1'b0, w_acc_sel} + {1'b0, r_prod[DiffW-1:0]};
    assign w_sum_norm = {1'b0, w_norm_sel} + {1'b0, r_prod[NormW-1:0]};
    assign w_sum_dot  = (DotW+1)'(w_dot_sel) + (DotW+1)'($signed(r_prod[47:0]));

    logic [DiffW-1:0] w_diff_sat;
    logic [NormW-1:0] w_norm_sat;
    logic signed [DotW-1:0] w_dot_sat;
    always_comb begin
        w_diff_sat = w_sum_diff[DiffW] ? DiffMax : w_sum_diff[DiffW-1:0];
        w_norm_sat = w_sum_norm[NormW] ? NormMax : w_sum_norm[NormW-1:0];
        if (w_sum_dot[DotW] != w_sum_dot[DotW-1]) begin
            w_dot_sat = w_sum_dot[DotW] ? {1'b1, {(DotW-1){1'b0}}} : {1'b0, {(DotW-1){1'b1}}};
        end else begin
            w_dot_sat = w_sum_dot[DotW-1:0];
        end
    end

    // Finish: values of the pair being worked on.
    logic [DiffW-1:0]       w_f_acc;
    logic signed [DotW-1:0] w_f_dot;
    logic [NormW-1:0]       w_f_nb;
    logic [DotW-1:0]        w_f_mag;
    logic [63:0]            w_f_mag6;
    assign w_f_acc  = r_pair ? r_acc_n : r_acc_p;
    assign w_f_dot  = r_pair ? r_dot_n : r_dot_p;
    assign w_f_nb   = r_pair ? r_norm_n : r_norm_p;
    assign w_f_mag  = w_f_dot[DotW-1] ? DotW'(-w_f_dot) : w_f_dot;
    assign w_f_mag6 = {1'b0, w_f_mag, 6'b0};

    // One step of the bit-pair square root.
    logic [63:0] w_bit, w_try, w_sq_v_nx, w_sq_r_nx;
    logic        w_sq_done;
    assign w_bit = 64'd1 << {~r_step, 1'b0};
    assign w_try = r_sq_r + w_bit;
    always_comb begin
        if (r_sq_v >= w_try) begin
            w_sq_v_nx = r_sq_v - w_try;
            w_sq_r_nx = (r_sq_r >> 1) + w_bit;
        end else begin
            w_sq_v_nx = r_sq_v;
            w_sq_r_nx = r_sq_r >> 1;
        end
    end
    assign w_sq_done = (r_step == 5'd31);

    // One step of the restoring divider.
    logic [63:0] w_rem2;
    logic        w_div_done;
    assign w_rem2     = {r_rem[62:0], 1'b0};
    assign w_div_done = (r_step == 5'(FracBits - 1));

    logic [17:0] w_cos_d;
    assign w_cos_d = w_f_dot[DotW-1] ? OneFix + 18'(r_q) : OneFix - 18'(r_q);

    logic signed [OutW+1:0] w_loss;
    logic [OutW-1:0]        w_loss_sat;
    assign w_loss = (OutW+2)'({2'b0, r_dap}) - (OutW+2)'({2'b0, r_dan})
                  + (OutW+2)'({12'b0, r_margin});
    always_comb begin
        if (w_loss[OutW+1])      w_loss_sat = '0;
        else if (w_loss[OutW])   w_loss_sat = OutMax;
        else                     w_loss_sat = w_loss[OutW-1:0];
    end

    logic w_in_acc, w_out_free;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (r_cnt_elem < CntW'(MaxDim)) n_state = ST_MUL;
                    else if (s_axis_tlast)          n_state = ST_FSEL;
                end
            end
            ST_MUL: n_state = ST_ACC;
            ST_ACC: begin
                if (r_k == w_k_last) n_state = r_last ? ST_FSEL : ST_IDLE;
                else                 n_state = ST_MUL;
            end
            ST_FSEL: begin
                if (r_mode == MetricCosine) begin
                    if (r_norm_a == '0 || w_f_nb == '0) n_state = ST_STORE;
                    else                                n_state = ST_SQA;
                end else if (r_mode == MetricManhat) begin
                    n_state = ST_STORE;
                end else begin
                    n_state = ST_SQD;
                end
            end
            ST_SQA:  if (w_sq_done) n_state = ST_SQB;
            ST_SQB:  if (w_sq_done) n_state = ST_MULD;
            ST_SQD:  if (w_sq_done) n_state = ST_STORE;
            ST_MULD: n_state = ST_DIVC;
            ST_DIVC: n_state = (w_f_mag6 >= r_den) ? ST_STORE : ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_STORE;
            ST_STORE: n_state = r_pair ? ST_LOSS : ST_FSEL;
            ST_LOSS: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MetricEuclid;
            r_margin    <= 24'(OneFix);
            r_cnt_elem  <= '0;
            r_acc_p     <= '0;
            r_acc_n     <= '0;
            r_dot_p     <= '0;
            r_dot_n     <= '0;
            r_norm_a    <= '0;
            r_norm_p    <= '0;
            r_norm_n    <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_pair      <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == RegMetric)      r_mode   <= i_cfg_data[1:0];
                else if (i_cfg_idx == RegMargin) r_margin <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_a    <= s_axis_tdata[ElemW-1:0];
                        r_p    <= s_axis_tdata[2*ElemW-1:ElemW];
                        r_n    <= s_axis_tdata[3*ElemW-1:2*ElemW];
                        r_last <= s_axis_tlast;
                        r_k    <= '0;
                        r_pair <= 1'b0;
                        if (r_cnt_elem < CntW'(MaxDim)) r_cnt_elem <= r_cnt_elem + 1'b1;
                    end
                end
                ST_MUL: begin
                    if (r_mode == MetricManhat) begin
                        r_prod <= 64'(r_k == 3'd0 ? w_abs_p : w_abs_n);
                    end else begin
                        r_prod <= w_mul[63:0];
                    end
                end
                ST_ACC: begin
                    r_k <= r_k + 1'b1;
                    if (r_mode == MetricCosine) begin
                        case (r_k)
                            3'd0:    r_dot_p  <= w_dot_sat;
                            3'd1:    r_dot_n  <= w_dot_sat;
                            3'd2:    r_norm_a <= w_norm_sat;
                            3'd3:    r_norm_p <= w_norm_sat;
                            default: r_norm_n <= w_norm_sat;
                        endcase
                    end else if (r_k == 3'd0) begin
                        r_acc_p <= w_diff_sat;
                    end else begin
                        r_acc_n <= w_diff_sat;
                    end
                end
                ST_FSEL: begin
                    r_step <= '0;
                    r_sq_r <= '0;
                    if (r_mode == MetricCosine) begin
                        r_sq_v <= {2'b0, r_norm_a, 6'b0};
                        r_d    <= OutW'(OneFix);
                    end else begin
                        r_sq_v <= 64'(w_f_acc);
                        r_d    <= (w_f_acc > DiffW'(OutMax)) ? OutMax : w_f_acc[OutW-1:0];
                    end
                end
                ST_SQA, ST_SQB, ST_SQD: begin
                    r_step <= r_step + 1'b1;
                    r_sq_v <= w_sq_v_nx;
                    r_sq_r <= w_sq_r_nx;
                    if (w_sq_done) begin
                        r_sq_v <= {2'b0, w_f_nb, 6'b0};
                        r_sq_r <= '0;
                        if (r_state == ST_SQA) r_sa <= w_sq_r_nx[31:0];
                        if (r_state == ST_SQB) r_sb <= w_sq_r_nx[31:0];
                        if (r_state == ST_SQD) r_d  <= OutW'(w_sq_r_nx[31:0]);
                    end
                end
                ST_MULD: r_den <= w_mul[63:0];
                ST_DIVC: begin
                    r_rem  <= w_f_mag6;
                    r_q    <= '0;
                    r_step <= '0;
                    r_d    <= OutW'(w_f_dot[DotW-1] ? OneFix + OneFix : 18'd0);
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (w_rem2 >= r_den) begin
                        r_rem <= w_rem2 - r_den;
                        r_q   <= {r_q[15:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2;
                        r_q   <= {r_q[15:0], 1'b0};
                    end
                end
                ST_STORE: begin
                    if (r_mode == MetricCosine && r_norm_a != '0 && w_f_nb != '0
                        && r_step != '0) begin
                        if (r_pair) r_dan <= OutW'(w_cos_d);
                        else        r_dap <= OutW'(w_cos_d);
                    end else begin
                        if (r_pair) r_dan <= r_d;
                        else        r_dap <= r_d;
                    end
                    r_pair <= 1'b1;
                end
                ST_LOSS: begin
                    if (w_out_free) begin
                        r_out       <= {r_dan, r_dap, w_loss_sat};
                        r_out_valid <= 1'b1;
                        r_cnt_elem  <= '0;
                        r_acc_p     <= '0;
                        r_acc_n     <= '0;
                        r_dot_p     <= '0;
                        r_dot_n     <= '0;
                        r_norm_a    <= '0;
                        r_norm_p    <= '0;
                        r_norm_n    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutDataW'(r_out);

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the triplet margin loss block with a built-in distance predictor.
`default_nettype none
module tb_top;
    import tml_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [33:0] OutMax  = {34{1'b1}};
    localparam logic [57:0] DiffMax = {58{1'b1}};
    localparam logic [55:0] NormMax = {56{1'b1}};

    typedef struct packed {
        logic [33:0] loss;
        logic [33:0] dpos;
        logic [33:0] dneg;
    } t_loss_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [InDataW-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    triplet_margin_loss DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [1:0] cur_metric;
    logic [23:0] cur_margin;
    logic [57:0] sum_ap, sum_an;
    logic signed [56:0] dot_ap, dot_an;
    logic [55:0] nrm_a, nrm_p, nrm_n;
    int dim_count;
    t_loss_beat loss_queue[$];
    int errors = 0;
    int send_idle = 0, recv_idle = 0;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] cosine_distance(logic signed [56:0] dot,
                                                    logic [55:0] na, logic [55:0] nb);
        logic [63:0] one, sa, sb, den, mag, q, r;
        one = 64'd1 << FracBits;
        if (na == 0 || nb == 0) return one;
        sa = int_sqrt({8'd0, na} << 6);
        sb = int_sqrt({8'd0, nb} << 6);
        den = sa * sb;
        mag = dot < 0 ? 64'(-dot) : 64'(dot);
        mag = mag << 6;
        if (mag >= den) begin
            q = one;
        end else begin
            q = 0;
            r = mag;
            for (int i = 0; i < FracBits; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
        end
        return dot < 0 ? one + q : one - q;
    endfunction

    function automatic logic [33:0] finish_distance(logic [57:0] acc, logic signed [56:0] dot,
                                                    logic [55:0] nb);
        logic [63:0] d;
        if (cur_metric == MetricCosine) d = cosine_distance(dot, nrm_a, nb);
        else if (cur_metric == MetricManhat) d = {6'd0, acc};
        else d = int_sqrt({6'd0, acc});
        return d > OutMax ? OutMax : d[33:0];
    endfunction

    function automatic logic [57:0] sat_diff(logic [57:0] acc, logic [63:0] v);
        logic [64:0] s;
        s = acc + v;
        return s > DiffMax ? DiffMax : s[57:0];
    endfunction

    function automatic logic [55:0] sat_norm(logic [55:0] acc, logic [63:0] v);
        logic [64:0] s;
        s = acc + v;
        return s > NormMax ? NormMax : s[55:0];
    endfunction

    function automatic logic signed [56:0] sat_dot(logic signed [56:0] acc,
                                                   logic signed [63:0] v);
        logic signed [64:0] s;
        s = acc + v;
        if (s > (65'sd1 <<< 56) - 1) return {1'b0, {56{1'b1}}};
        if (s < -(65'sd1 <<< 56)) return {1'b1, 56'd0};
        return s[56:0];
    endfunction

    task automatic clear_sums();
        sum_ap = 0; sum_an = 0; dot_ap = 0; dot_an = 0;
        nrm_a = 0; nrm_p = 0; nrm_n = 0; dim_count = 0;
    endtask

    task automatic predict_component(logic [23:0] ra, logic [23:0] rp, logic [23:0] rn,
                                     logic last);
        logic signed [63:0] a, p, n, dp, dn, lv;
        t_loss_beat res;
        a = 64'(signed'(ra));
        p = 64'(signed'(rp));
        n = 64'(signed'(rn));
        if (dim_count < MaxDim) begin
            dim_count++;
            if (cur_metric == MetricCosine) begin
                dot_ap = sat_dot(dot_ap, a * p);
                dot_an = sat_dot(dot_an, a * n);
                nrm_a = sat_norm(nrm_a, a * a);
                nrm_p = sat_norm(nrm_p, p * p);
                nrm_n = sat_norm(nrm_n, n * n);
            end else begin
                dp = a - p;
                dn = a - n;
                if (cur_metric == MetricManhat) begin
                    sum_ap = sat_diff(sum_ap, dp < 0 ? -dp : dp);
                    sum_an = sat_diff(sum_an, dn < 0 ? -dn : dn);
                end else begin
                    sum_ap = sat_diff(sum_ap, dp * dp);
                    sum_an = sat_diff(sum_an, dn * dn);
                end
            end
        end
        if (last) begin
            res.dpos = finish_distance(sum_ap, dot_ap, nrm_p);
            res.dneg = finish_distance(sum_an, dot_an, nrm_n);
            lv = 64'(res.dpos) - 64'(res.dneg) + 64'(cur_margin);
            if (lv < 0) lv = 0;
            if (lv > 64'(OutMax)) lv = 64'(OutMax);
            res.loss = lv[33:0];
            loss_queue.push_back(res);
            clear_sums();
        end
    endtask

    // The block is busy after each beat, so the extra edge costs nothing.
    task automatic send_component(logic [23:0] a, logic [23:0] p, logic [23:0] n, logic last);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {n, p, a};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_component(a, p, n, last);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the block to drain, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        while (loss_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegMetric) cur_metric = val[1:0];
        else if (idx == RegMargin) cur_margin = val;
    endtask

    function automatic logic [23:0] rand_elem(int span);
        logic signed [23:0] v;
        case ($urandom_range(9))
            0: v = 24'h7FFFFF;
            1: v = 24'h800000;
            2: v = 24'(signed'($urandom()));
            default: v = 24'(int'($urandom_range(2 * span)) - span);
        endcase
        return v;
    endfunction

    task automatic send_vector(int len, int span);
        for (int i = 0; i < len; i++)
            send_component(rand_elem(span), rand_elem(span), rand_elem(span), i == len - 1);
    endtask

    task automatic test_directed();
        write_reg(RegMetric, MetricEuclid);
        send_component(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1);
        send_component(24'h800000, 24'h7FFFFF, 24'h000000, 1'b1);
        send_component(24'h000000, 24'h000000, 24'h000000, 1'b1);
        write_reg(RegMetric, MetricCosine);
        send_component(24'h000000, 24'h010000, 24'h010000, 1'b1);    // zero norm
        send_component(24'h010000, 24'h010000, 24'hFF0000, 1'b1);    // cos +1 and -1
        send_component(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b0);
        send_component(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b1);
        write_reg(RegMetric, MetricManhat);
        write_reg(RegMargin, 24'hFFFFFF);
        send_component(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1);
        send_component(24'h012345, 24'h012000, 24'hFEDCBA, 1'b1);
        write_reg(RegMargin, 24'h000000);
        send_component(24'h000000, 24'h000000, 24'h7FFFFF, 1'b1);
        write_reg(RegMetric, 2'd3);                                   // unused code
        send_component(24'h001000, 24'h002000, 24'h003000, 1'b1);
    endtask

    // Metric switches mid-vector; the finish follows the metric at the last beat.
    task automatic test_metric_switch();
        write_reg(RegMargin, 24'h010000);
        write_reg(RegMetric, MetricManhat);
        send_component(24'h020000, 24'h010000, 24'hFF0000, 1'b0);
        // Let the accumulate steps of the first beat finish before the metric changes.
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= RegMetric;
        i_cfg_data <= {22'd0, MetricCosine};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_metric = MetricCosine;
        send_component(24'h010000, 24'h030000, 24'h008000, 1'b1);
    endtask

    // Long vectors exceed the element limit.
    task automatic test_long_vectors();
        write_reg(RegMetric, MetricManhat);
        for (int i = 0; i < 300; i++)
            send_component(24'h7FFFFF, 24'h800000, 24'h800000, i == 299);
    endtask

    task automatic test_random(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                write_reg(RegMetric, 2'($urandom_range(3)));
                write_reg(RegMargin, $urandom_range(3) == 0 ? 24'($urandom()) :
                          24'($urandom_range(24'h040000)));
            end
            len = $urandom_range(1, 8);
            send_vector(len, $urandom_range(1) ? 24'h040000 : 24'h7FFFFF);
            sent += len;
        end
    endtask

    always @(posedge i_clk) begin
        t_loss_beat got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[33:0], m_axis_tdata[67:34], m_axis_tdata[101:68]};
                if (loss_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = loss_queue.pop_front();
                    if (got.loss !== want.loss) begin
                        $error("loss_value expected %0d got %0d", want.loss, got.loss);
                        errors++;
                    end
                    if (got.dpos !== want.dpos) begin
                        $error("dist_positive expected %0d got %0d", want.dpos, got.dpos);
                        errors++;
                    end
                    if (got.dneg !== want.dneg) begin
                        $error("dist_negative expected %0d got %0d", want.dneg, got.dneg);
                        errors++;
                    end
                end
            end
            m_axis_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    initial begin
        cur_metric = MetricEuclid;
        cur_margin = 24'h010000;
        clear_sums();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle = 33;
        recv_idle = 73;
        test_directed();
        test_metric_switch();
        test_random(250);
        send_idle = 73;
        recv_idle = 33;
        test_long_vectors();
        test_random(250);
        send_idle = 0;
        recv_idle = 0;
        test_random(300);
        while (loss_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
